// ===== hw/rtl/rotate_bilinear_sampler_core_macros.svh =====
// Assertion macros shared by the rotate/bilinear sampler RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ROTATE_BILINEAR_SAMPLER_CORE_MACROS_SVH
`define ROTATE_BILINEAR_SAMPLER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define RBS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define RBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rbs_pkg.sv =====
// Shared types and constants for the rotate/bilinear sampler.
// No dependencies; used by every module of the block.
package rbs_pkg;

    // Request codes
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_SRC_W = 3'd0;
    localparam logic [2:0] CFG_SRC_H = 3'd1;
    localparam logic [2:0] CFG_DST_W = 3'd2;
    localparam logic [2:0] CFG_DST_H = 3'd3;
    localparam logic [2:0] CFG_COS   = 3'd4;
    localparam logic [2:0] CFG_SIN   = 3'd5;

    // Source positions are in units of 2^-15 pixel
    localparam int POS_SHIFT = 15;

    // Geometry as seen by the datapath (source sizes already clamped)
    typedef struct packed {
        logic [8:0]         w;
        logic [8:0]         h;
        logic [9:0]         dst_w;
        logic [9:0]         dst_h;
        logic signed [15:0] cos_q;
        logic signed [15:0] sin_q;
    } t_geo;

    // Transform stage output: one beat with its source position
    typedef struct packed {
        logic               valid;
        logic               is_load;
        logic [8:0]         col;
        logic [8:0]         row;
        logic [23:0]        rgb;
        logic signed [29:0] sx;
        logic signed [29:0] sy;
    } t_xf;

    // Fetched neighbors of one sample
    typedef struct packed {
        logic        valid;
        logic        in_src;
        logic [23:0] p00;
        logic [23:0] p01;
        logic [23:0] p10;
        logic [23:0] p11;
    } t_tap;

endpackage

// ===== hw/rtl/rbs_xform.sv =====
// Coordinate transform: destination offset times cos/sin, then the sums
// that give the source position. Depends on rbs_pkg.
module rbs_xform (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_take,
    input  logic          i_req_type,
    input  logic [8:0]    i_col,
    input  logic [8:0]    i_row,
    input  logic [23:0]   i_rgb,
    input  rbs_pkg::t_geo i_geo,
    output rbs_pkg::t_xf  o_xf
);

    logic signed [11:0] w_xh;
    logic signed [11:0] w_yh;
    logic signed [27:0] n_pxc, n_pys, n_pxs, n_pyc;

    logic               r1_valid;
    logic               r1_load;
    logic [8:0]         r1_col, r1_row;
    logic [23:0]        r1_rgb;
    logic signed [27:0] r1_pxc, r1_pys, r1_pxs, r1_pyc;

    logic               r2_valid;
    logic               r2_load;
    logic [8:0]         r2_col, r2_row;
    logic [23:0]        r2_rgb;
    logic signed [29:0] r2_sx, r2_sy;
    logic signed [29:0] n_sx, n_sy;

    // Half-pixel offsets from the destination center, and the four products
    always_comb begin
        w_xh  = signed'({2'b00, i_col, 1'b0}) - signed'({2'b00, i_geo.dst_w});
        w_yh  = signed'({2'b00, i_row, 1'b0}) - signed'({2'b00, i_geo.dst_h});
        n_pxc = w_xh * i_geo.cos_q;
        n_pys = w_yh * i_geo.sin_q;
        n_pxs = w_xh * i_geo.sin_q;
        n_pyc = w_yh * i_geo.cos_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_load <= (i_req_type == rbs_pkg::REQ_LOAD);
            r1_col  <= i_col;
            r1_row  <= i_row;
            r1_rgb  <= i_rgb;
            r1_pxc  <= n_pxc;
            r1_pys  <= n_pys;
            r1_pxs  <= n_pxs;
            r1_pyc  <= n_pyc;
        end
    end

    // Rotate back about the source center
    always_comb begin
        n_sx = 30'(r1_pxc) + 30'(r1_pys) + signed'({7'b0, i_geo.w, 14'b0});
        n_sy = 30'(r1_pyc) - 30'(r1_pxs) + signed'({7'b0, i_geo.h, 14'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_load <= r1_load;
            r2_col  <= r1_col;
            r2_row  <= r1_row;
            r2_rgb  <= r1_rgb;
            r2_sx   <= n_sx;
            r2_sy   <= n_sy;
        end
    end

    always_comb begin
        o_xf.valid   = r2_valid;
        o_xf.is_load = r2_load;
        o_xf.col     = r2_col;
        o_xf.row     = r2_row;
        o_xf.rgb     = r2_rgb;
        o_xf.sx      = r2_sx;
        o_xf.sy      = r2_sy;
    end

endmodule

// ===== hw/rtl/rbs_fetch.sv =====
// Inside test, tap/weight split and the frame store, banked by row and
// column parity so four neighbors read together. Depends on rbs_pkg.
`include "rotate_bilinear_sampler_core_macros.svh"
module rbs_fetch #(
    parameter int MAX_SIDE    = 256,
    parameter int FRAC_BITS   = 14,
    parameter int WEIGHT_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  rbs_pkg::t_geo          i_geo,
    input  rbs_pkg::t_xf           i_xf,
    output rbs_pkg::t_tap          o_tap,
    output logic [WEIGHT_BITS-1:0] o_wx,
    output logic [WEIGHT_BITS-1:0] o_wy
);

    localparam int HALF  = (MAX_SIDE + 1) / 2;
    localparam int DEPTH = HALF * HALF;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                   w_inside;
    logic [8:0]             w_x0, w_y0, w_x1, w_y1;
    logic [9:0]             w_x0p1, w_y0p1;
    logic [14:0]            w_sx15, w_sy15;
    logic [FRAC_BITS-1:0]   w_frx, w_fry;
    logic [WEIGHT_BITS-1:0] w_wx, w_wy;
    logic                   w_ld_ok;
    logic [3:0]             w_we;
    logic [23:0]            w_rd [4];

    logic                   r4_valid;
    logic                   r4_load;
    logic                   r4_inside;
    logic [WEIGHT_BITS-1:0] r4_wx, r4_wy;
    logic                   r4_x0p, r4_x1p, r4_y0p, r4_y1p;

    // Inside test and integer taps with edge clamp
    always_comb begin
        w_inside = !i_xf.sx[29] && !i_xf.sy[29] &&
                   (i_xf.sx[28:0] < {5'b0, i_geo.w, 15'b0}) &&
                   (i_xf.sy[28:0] < {5'b0, i_geo.h, 15'b0});
        w_x0     = i_xf.sx[23:15];
        w_y0     = i_xf.sy[23:15];
        w_x0p1   = {1'b0, w_x0} + 10'd1;
        w_y0p1   = {1'b0, w_y0} + 10'd1;
        w_x1     = (w_x0p1 >= {1'b0, i_geo.w}) ? i_geo.w - 9'd1 : w_x0p1[8:0];
        w_y1     = (w_y0p1 >= {1'b0, i_geo.h}) ? i_geo.h - 9'd1 : w_y0p1[8:0];
        w_sx15   = i_xf.sx[14:0];
        w_sy15   = i_xf.sy[14:0];
        w_ld_ok  = i_xf.valid && i_xf.is_load &&
                   (i_xf.col < i_geo.w) && (i_xf.row < i_geo.h);
    end

    // Fraction truncated or zero-padded to FRAC_BITS
    generate
        if (FRAC_BITS >= rbs_pkg::POS_SHIFT) begin : g_fr_wide
            assign w_frx = FRAC_BITS'(w_sx15) << (FRAC_BITS - rbs_pkg::POS_SHIFT);
            assign w_fry = FRAC_BITS'(w_sy15) << (FRAC_BITS - rbs_pkg::POS_SHIFT);
        end else begin : g_fr_narrow
            assign w_frx = w_sx15[14 -: FRAC_BITS];
            assign w_fry = w_sy15[14 -: FRAC_BITS];
        end
    endgenerate

    // Blend weight from the fraction
    generate
        if (FRAC_BITS >= WEIGHT_BITS) begin : g_wt_trunc
            assign w_wx = w_frx[FRAC_BITS-1 -: WEIGHT_BITS];
            assign w_wy = w_fry[FRAC_BITS-1 -: WEIGHT_BITS];
        end else begin : g_wt_pad
            assign w_wx = WEIGHT_BITS'(w_frx) << (WEIGHT_BITS - FRAC_BITS);
            assign w_wy = WEIGHT_BITS'(w_fry) << (WEIGHT_BITS - FRAC_BITS);
        end
    endgenerate

    // Four banks: bank index is {row parity, column parity}
    genvar gb;
    generate
        for (gb = 0; gb < 4; gb++) begin : g_bank
            localparam logic RX = 1'(gb % 2);
            localparam logic RY = 1'(gb / 2);

            logic [8:0]    w_c, w_r;
            logic [AW-1:0] w_raddr, w_waddr;
            logic [23:0]   r_mem [DEPTH];
            logic [23:0]   r_rd;

            always_comb begin
                w_c      = (w_x0[0] == RX) ? w_x0 : w_x1;
                w_r      = (w_y0[0] == RY) ? w_y0 : w_y1;
                w_raddr  = AW'(int'(w_r[8:1]) * HALF + int'(w_c[8:1]));
                w_waddr  = AW'(int'(i_xf.row[8:1]) * HALF + int'(i_xf.col[8:1]));
                w_we[gb] = w_ld_ok && (i_xf.row[0] == RY) && (i_xf.col[0] == RX);
            end

            always_ff @(posedge i_clk) begin
                if (i_en && w_we[gb]) begin
                    r_mem[w_waddr] <= i_xf.rgb;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rd <= r_mem[w_raddr];
                end
            end

            assign w_rd[gb] = r_rd;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= i_xf.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_load   <= i_xf.is_load;
            r4_inside <= w_inside;
            r4_wx     <= w_wx;
            r4_wy     <= w_wy;
            r4_x0p    <= w_x0[0];
            r4_x1p    <= w_x1[0];
            r4_y0p    <= w_y0[0];
            r4_y1p    <= w_y1[0];
        end
    end

    function automatic logic [23:0] pick(input logic ry, input logic rx,
                                         input logic [23:0] d0, input logic [23:0] d1,
                                         input logic [23:0] d2, input logic [23:0] d3);
        logic [23:0] v;
        if (ry) begin
            v = rx ? d3 : d2;
        end else begin
            v = rx ? d1 : d0;
        end
        return v;
    endfunction

    // Route bank words to neighbor positions
    always_comb begin
        o_tap.valid  = r4_valid && !r4_load;
        o_tap.in_src = r4_inside;
        o_tap.p00    = pick(r4_y0p, r4_x0p, w_rd[0], w_rd[1], w_rd[2], w_rd[3]);
        o_tap.p01    = pick(r4_y0p, r4_x1p, w_rd[0], w_rd[1], w_rd[2], w_rd[3]);
        o_tap.p10    = pick(r4_y1p, r4_x0p, w_rd[0], w_rd[1], w_rd[2], w_rd[3]);
        o_tap.p11    = pick(r4_y1p, r4_x1p, w_rd[0], w_rd[1], w_rd[2], w_rd[3]);
        o_wx         = r4_wx;
        o_wy         = r4_wy;
    end

    // Taps of an inside sample stay within the source image
    `RBS_ASSERT_SAME(a_tap_range, i_clk, i_rst_n, i_xf.valid && !i_xf.is_load && w_inside, (w_x0 < i_geo.w) && (w_y0 < i_geo.h) && (w_x1 < i_geo.w) && (w_y1 < i_geo.h), "tap outside source image")
    // A load writes at most one bank
    `RBS_ASSERT_SAME(a_one_bank, i_clk, i_rst_n, 1'b1, $onehot0(w_we), "load hits several banks")
    // Samples never write the store
    `RBS_ASSERT_SAME(a_no_sample_write, i_clk, i_rst_n, i_xf.valid && !i_xf.is_load, w_we == 4'b0, "sample wrote the frame store")

endmodule

// ===== hw/rtl/rbs_blend.sv =====
// Bilinear blend: weight products, per-channel tap products, sums and the
// output register. Depends on rbs_pkg.
`include "rotate_bilinear_sampler_core_macros.svh"
module rbs_blend #(
    parameter int WEIGHT_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  rbs_pkg::t_tap          i_tap,
    input  logic [WEIGHT_BITS-1:0] i_wx,
    input  logic [WEIGHT_BITS-1:0] i_wy,
    output logic                   o_valid,
    output logic [7:0]             o_red,
    output logic [7:0]             o_green,
    output logic [7:0]             o_blue,
    output logic                   o_inside
);

    localparam int OW = WEIGHT_BITS + 1;
    localparam int WW = 2 * OW;
    localparam int PW = WW + 8;
    localparam logic [OW-1:0] ONE = OW'(1) << WEIGHT_BITS;

    logic [OW-1:0] w_ox, w_oy, w_wx, w_wy;

    logic          r5_valid;
    logic          r5_inside;
    logic [WW-1:0] r5_w [4];
    logic [23:0]   r5_p [4];

    logic          r6_valid;
    logic          r6_inside;
    logic [PW-1:0] r6_prod [3][4];

    logic          r7_valid;
    logic          r7_inside;
    logic [7:0]    r7_red, r7_green, r7_blue;
    logic [PW-1:0] n_sum [3];

    // Corner weights
    always_comb begin
        w_wx = {1'b0, i_wx};
        w_wy = {1'b0, i_wy};
        w_ox = ONE - w_wx;
        w_oy = ONE - w_wy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r7_valid <= 1'b0;
        end else if (i_en) begin
            r5_valid <= i_tap.valid;
            r6_valid <= r5_valid;
            r7_valid <= r6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_inside <= i_tap.in_src;
            r5_w[0]   <= w_ox * w_oy;
            r5_w[1]   <= w_wx * w_oy;
            r5_w[2]   <= w_ox * w_wy;
            r5_w[3]   <= w_wx * w_wy;
            r5_p[0]   <= i_tap.p00;
            r5_p[1]   <= i_tap.p01;
            r5_p[2]   <= i_tap.p10;
            r5_p[3]   <= i_tap.p11;
        end
    end

    // Weight times channel, one product per tap and channel
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_inside <= r5_inside;
            for (int c = 0; c < 3; c++) begin
                for (int k = 0; k < 4; k++) begin
                    r6_prod[c][k] <= PW'(r5_w[k]) * PW'(r5_p[k][23 - 8*c -: 8]);
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_sum[c] = r6_prod[c][0] + r6_prod[c][1] + r6_prod[c][2] + r6_prod[c][3];
        end
    end

    // Output register; black when outside
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_inside <= r6_inside;
            r7_red    <= r6_inside ? n_sum[0][2*WEIGHT_BITS +: 8] : 8'd0;
            r7_green  <= r6_inside ? n_sum[1][2*WEIGHT_BITS +: 8] : 8'd0;
            r7_blue   <= r6_inside ? n_sum[2][2*WEIGHT_BITS +: 8] : 8'd0;
        end
    end

    assign o_valid  = r7_valid;
    assign o_inside = r7_inside;
    assign o_red    = r7_red;
    assign o_green  = r7_green;
    assign o_blue   = r7_blue;

    // Outside samples come out black
    `RBS_ASSERT_SAME(a_black_outside, i_clk, i_rst_n, r7_valid && !r7_inside, (r7_red == 8'd0) && (r7_green == 8'd0) && (r7_blue == 8'd0), "outside pixel not black")
    // A beat in the product stage reaches the output register
    `RBS_ASSERT_NEXT(a_advance, i_clk, i_rst_n, i_en && r6_valid, r7_valid, "beat lost before output")
    // A held output beat keeps its payload
    `RBS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r7_valid && !i_en, r7_valid && $stable({r7_red, r7_green, r7_blue, r7_inside}), "held output beat changed")

endmodule

// ===== hw/rtl/rotate_bilinear_sampler_core.sv =====
// Rotating bilinear sampler, top level: config registers, pipeline enable
// and the transform, fetch and blend stages. Depends on rbs_pkg and rbs_*.
//
// Loads write an RGB pixel into a four-bank frame store (banked by row and
// column parity); samples return one rotated, bilinearly blended pixel.
// One beat is taken every clock while the output is not held, loads and
// samples alike; a sample's result passes through the six register stages
// (two transform stages, the registered frame-store read, weight products,
// tap products, sum/output register). The four banks each give one read
// per clock, which is what lets all four neighbors come in the same cycle.
// A held output stalls the whole pipeline, input included. Config writes
// are taken at any time but should only be issued with the pipe empty.
module rotate_bilinear_sampler_core #(
    parameter int MAX_SIDE    = 256,
    parameter int FRAC_BITS   = 14,
    parameter int WEIGHT_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [8:0]  i_col,
    input  logic [8:0]  i_row,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out,
    output logic        o_inside_res
);

    logic [8:0]             r_src_w, r_src_h;
    logic [9:0]             r_dst_w, r_dst_h;
    logic signed [15:0]     r_cos, r_sin;
    rbs_pkg::t_geo          w_geo;
    logic                   w_en;
    logic                   w_take;
    rbs_pkg::t_xf           w_xf;
    rbs_pkg::t_tap          w_tap;
    logic [WEIGHT_BITS-1:0] w_wx, w_wy;

    // Config register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= 9'd256;
            r_src_h <= 9'd256;
            r_dst_w <= 10'd256;
            r_dst_h <= 10'd256;
            r_cos   <= 16'sd16384;
            r_sin   <= 16'sd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rbs_pkg::CFG_SRC_W: r_src_w <= i_cfg_data[8:0];
                rbs_pkg::CFG_SRC_H: r_src_h <= i_cfg_data[8:0];
                rbs_pkg::CFG_DST_W: r_dst_w <= i_cfg_data[9:0];
                rbs_pkg::CFG_DST_H: r_dst_h <= i_cfg_data[9:0];
                rbs_pkg::CFG_COS:   r_cos   <= signed'(i_cfg_data);
                rbs_pkg::CFG_SIN:   r_sin   <= signed'(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Source sizes clamped to the store
    always_comb begin
        w_geo.w     = (int'(r_src_w) > MAX_SIDE) ? 9'(MAX_SIDE) : r_src_w;
        w_geo.h     = (int'(r_src_h) > MAX_SIDE) ? 9'(MAX_SIDE) : r_src_h;
        w_geo.dst_w = r_dst_w;
        w_geo.dst_h = r_dst_h;
        w_geo.cos_q = r_cos;
        w_geo.sin_q = r_sin;
    end

    // Pipeline advances unless a finished result is held
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;
    assign w_take     = i_in_valid && w_en;

    rbs_xform u_xform (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_take     (w_take),
        .i_req_type (i_req_type),
        .i_col      (i_col),
        .i_row      (i_row),
        .i_rgb      ({i_red_in, i_green_in, i_blue_in}),
        .i_geo      (w_geo),
        .o_xf       (w_xf)
    );

    rbs_fetch #(
        .MAX_SIDE    (MAX_SIDE),
        .FRAC_BITS   (FRAC_BITS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_fetch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_geo   (w_geo),
        .i_xf    (w_xf),
        .o_tap   (w_tap),
        .o_wx    (w_wx),
        .o_wy    (w_wy)
    );

    rbs_blend #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_tap    (w_tap),
        .i_wx     (w_wx),
        .i_wy     (w_wy),
        .o_valid  (o_out_valid),
        .o_red    (o_red_out),
        .o_green  (o_green_out),
        .o_blue   (o_blue_out),
        .o_inside (o_inside_res)
    );

endmodule
